// ===== src/bcmt_pkg.sv =====
// shared types and constants of the boundary curve membership test
`default_nettype none
package bcmt_pkg;

	// coordinate storage and arithmetic widths
	localparam int CW      = 32;          // stored coordinate
	localparam int DW      = CW + 1;      // coordinate difference
	localparam int PW      = 2 * DW;      // product of two differences
	localparam int SW      = PW + 1;      // sum of two products
	localparam int RW      = 62;          // squared radius
	localparam int TW      = 16;          // tolerance
	localparam int BA      = 100;         // long multiplier, first operand
	localparam int BB      = 72;          // long multiplier, second operand
	localparam int BP      = BA + BB;     // long multiplier, product
	localparam int DIGIT   = 8;           // bits of the second operand per cycle

	// stream widths
	localparam int IN_W    = 256;
	localparam int USER_W  = 3;
	localparam int OUT_W   = 8;

	typedef logic [1:0] req_t;
	localparam req_t REQ_CLEAR  = 2'd0;
	localparam req_t REQ_APPEND = 2'd1;
	localparam req_t REQ_TEST   = 2'd2;

	typedef logic [1:0] dir_t;
	localparam dir_t DIR_NONE = 2'd0;
	localparam dir_t DIR_SAME = 2'd1;
	localparam dir_t DIR_OPP  = 2'd2;

	// one stored curve, one memory word
	typedef struct packed {
		logic [RW-1:0]        rsq;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] ey;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] sx;
		logic                 ccw;
		logic                 arc;
	} entry_t;

endpackage
`default_nettype wire

// ===== src/bcmt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module bcmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/bcmt_bigmul.sv =====
// sequential long unsigned multiplier, one digit of the second operand per cycle
`default_nettype none
module bcmt_bigmul
	import bcmt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [BA-1:0] a,
	input  wire logic [BB-1:0] b,
	output logic               done,
	output logic      [BP-1:0] p
);

	localparam int NDIG  = BB / DIGIT;
	localparam int CNT_W = $clog2(NDIG + 1);

	logic [BA-1:0]       a_q;
	logic [BB-1:0]       b_q;
	logic [BP-1:0]       acc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [BA+DIGIT-1:0] pp;

	// partial product of the top remaining digit
	assign pp = a_q * b_q[BB-1 -: DIGIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NDIG);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << DIGIT) + BP'(pp);
			b_q   <= b_q << DIGIT;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule
`default_nettype wire

// ===== src/boundary_curve_membership_test.sv =====
// top level: curve table in ram, scan sequencer, shared multiply-accumulate
// clear and append answer without a scan; a query scans every stored entry and
// uses the one 33x33 multiplier for each cross or dot product and, on segments,
// the long multiplier
// one request is worked at a time; the next is taken while a result waits
// reset: curve table empty, tolerance 66; ram contents are not cleared
`default_nettype none
module boundary_curve_membership_test
	import bcmt_pkg::*;
#(
	parameter int MAX_CURVES = 64,
	parameter int COORD_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// counter_clockwise, start_x, start_y, end_x, end_y, center_x, center_y,
	// radius_squared, zero pad
	input  wire logic [IN_W-1:0]   s_axis_tdata,
	// req_type, is_arc
	input  wire logic [USER_W-1:0] s_axis_tuser,
	// result stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// on_boundary, direction, table_full, zero pad
	output logic      [OUT_W-1:0]  m_axis_tdata,
	// tolerance register write
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [TW-1:0]     cfg_data
);

	localparam int AW    = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
	localparam int CNT_W = $clog2(MAX_CURVES + 1);
	localparam int SH    = CW - COORD_BITS;

	// sequencer states
	typedef enum logic [17:0] {
		ST_IDLE = 18'h00001,
		ST_RD   = 18'h00002,
		ST_DEG  = 18'h00004,
		ST_SEGX = 18'h00008,
		ST_SEGA = 18'h00010,
		ST_BM1  = 18'h00020,
		ST_BM2  = 18'h00040,
		ST_BM3  = 18'h00080,
		ST_ARAD = 18'h00100,
		ST_ARV  = 18'h00200,
		ST_DRV  = 18'h00400,
		ST_ARL  = 18'h00800,
		ST_DRL  = 18'h01000,
		ST_AVL  = 18'h02000,
		ST_DIRS = 18'h04000,
		ST_DIRA = 18'h08000,
		ST_NEXT = 18'h10000,
		ST_DONE = 18'h20000
	} st_t;

	// keep the low coordinate bits, sign extended
	function automatic logic signed [CW-1:0] sext(input logic [CW-1:0] v);
		sext = $signed(v << SH) >>> SH;
	endfunction

	// sweep quadrant class of v against the reference
	function automatic logic [1:0] sweep_cls(input logic signed [SW-1:0] x,
		input logic signed [SW-1:0] d);
		if (x > 0) sweep_cls = 2'd1;
		else if (x < 0) sweep_cls = 2'd3;
		else if (d < 0) sweep_cls = 2'd2;
		else sweep_cls = 2'd0;
	endfunction

	st_t state_q;
	st_t ok_state;

	// request fields
	logic                 acc_in;
	req_t                 in_req;
	entry_t               in_ent;

	// tolerance
	logic [TW-1:0]        tol_q;
	logic [2*TW-1:0]      t2_q;

	// table
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     k_q;
	logic                 ram_we;
	logic                 ram_re;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t               ent;

	// query held during the scan
	logic                 q_arc_q;
	logic                 q_ccw_q;
	logic signed [CW-1:0] qsx_q, qsy_q, qex_q, qey_q, qcx_q, qcy_q;
	logic                 pt_sel_q;

	// result
	logic                 on_q;
	dir_t                 dir_q;
	logic                 full_q;
	logic                 mvalid_q;
	logic [3:0]           out_q;

	// multiply-accumulate
	logic [1:0]           ph_q;
	logic                 mac_st;
	logic signed [DW-1:0] x1, y1, x2, y2;
	logic                 sub;
	logic signed [PW-1:0] mul_q;
	logic signed [PW-1:0] first_q;
	logic signed [SW-1:0] sum;
	logic                 fin;

	// kept partial results
	logic signed [SW-1:0] ab2_q, cr_q, ap2_q, xrv_q, xrl_q;
	logic [1:0]           cls_v_q, cls_l_q;
	logic [SW-1:0]        cr_abs;
	logic [BA-1:0]        m2_q;
	logic [BP-1:0]        c2_q;

	// long multiplier
	logic                 bm_start_q;
	logic [BA-1:0]        bm_a_q;
	logic [BB-1:0]        bm_b_q;
	logic                 bm_done;
	logic [BP-1:0]        bm_p;

	// geometry
	logic signed [CW-1:0] px, py;
	logic signed [DW-1:0] abx, aby, apx, apy, rpx, rpy;
	logic signed [DW-1:0] rsx, rsy, rex, rey, refx, refy, limx, limy;
	logic signed [DW-1:0] qdx, qdy, dcx, dcy;
	logic [SW-1:0]        rad_d, rad_diff;
	logic                 rad_bad;
	logic                 in_box;
	logic                 seg_bad;
	logic                 sweep_ok;

	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

	assign in_req     = s_axis_tuser[1:0];
	assign in_ent.arc = s_axis_tuser[2];
	assign in_ent.ccw = s_axis_tdata[0];
	assign in_ent.sx  = sext(s_axis_tdata[32:1]);
	assign in_ent.sy  = sext(s_axis_tdata[64:33]);
	assign in_ent.ex  = sext(s_axis_tdata[96:65]);
	assign in_ent.ey  = sext(s_axis_tdata[128:97]);
	assign in_ent.cx  = sext(s_axis_tdata[160:129]);
	assign in_ent.cy  = sext(s_axis_tdata[192:161]);
	assign in_ent.rsq = s_axis_tdata[254:193];

	// append writes the next free entry straight from the request
	assign ram_we = acc_in && (in_req == REQ_APPEND) && (count_q < CNT_W'(MAX_CURVES));
	assign ram_re = (state_q == ST_RD);

	bcmt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_CURVES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_ent),
		.re    (ram_re),
		.raddr (k_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// read data holds until the next read, so it serves the whole entry
	assign ent = entry_t'(ram_rdata);

	bcmt_bigmul u_bigmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bm_start_q),
		.a      (bm_a_q),
		.b      (bm_b_q),
		.done   (bm_done),
		.p      (bm_p)
	);

	// point under test: query start, then query end
	assign px = pt_sel_q ? qex_q : qsx_q;
	assign py = pt_sel_q ? qey_q : qsy_q;

	assign abx  = DW'(ent.ex) - DW'(ent.sx);
	assign aby  = DW'(ent.ey) - DW'(ent.sy);
	assign apx  = DW'(px) - DW'(ent.sx);
	assign apy  = DW'(py) - DW'(ent.sy);
	assign rpx  = DW'(px) - DW'(ent.cx);
	assign rpy  = DW'(py) - DW'(ent.cy);
	assign rsx  = DW'(ent.sx) - DW'(ent.cx);
	assign rsy  = DW'(ent.sy) - DW'(ent.cy);
	assign rex  = DW'(ent.ex) - DW'(ent.cx);
	assign rey  = DW'(ent.ey) - DW'(ent.cy);
	// a clockwise arc is the counterclockwise test with its ends swapped
	assign refx = ent.ccw ? rsx : rex;
	assign refy = ent.ccw ? rsy : rey;
	assign limx = ent.ccw ? rex : rsx;
	assign limy = ent.ccw ? rey : rsy;
	assign qdx  = DW'(qex_q) - DW'(qsx_q);
	assign qdy  = DW'(qey_q) - DW'(qsy_q);
	assign dcx  = DW'(ent.cx) - DW'(qcx_q);
	assign dcy  = DW'(ent.cy) - DW'(qcy_q);

	// operand pairs of each two-product step: x1*y1 +/- x2*y2
	always_comb begin
		x1 = abx; y1 = abx; x2 = aby; y2 = aby; sub = 1'b0; mac_st = 1'b1;
		unique case (state_q)
			ST_DEG:  begin x1 = abx;  y1 = abx;  x2 = aby;  y2 = aby;  sub = 1'b0; end
			ST_SEGX: begin x1 = abx;  y1 = apy;  x2 = aby;  y2 = apx;  sub = 1'b1; end
			ST_SEGA: begin x1 = apx;  y1 = apx;  x2 = apy;  y2 = apy;  sub = 1'b0; end
			ST_ARAD: begin x1 = rpx;  y1 = rpx;  x2 = rpy;  y2 = rpy;  sub = 1'b0; end
			ST_ARV:  begin x1 = refx; y1 = rpy;  x2 = refy; y2 = rpx;  sub = 1'b1; end
			ST_DRV:  begin x1 = refx; y1 = rpx;  x2 = refy; y2 = rpy;  sub = 1'b0; end
			ST_ARL:  begin x1 = refx; y1 = limy; x2 = refy; y2 = limx; sub = 1'b1; end
			ST_DRL:  begin x1 = refx; y1 = limx; x2 = refy; y2 = limy; sub = 1'b0; end
			ST_AVL:  begin x1 = rpx;  y1 = limy; x2 = rpy;  y2 = limx; sub = 1'b1; end
			ST_DIRS: begin x1 = qdx;  y1 = abx;  x2 = qdy;  y2 = aby;  sub = 1'b0; end
			ST_DIRA: begin x1 = dcx;  y1 = dcx;  x2 = dcy;  y2 = dcy;  sub = 1'b0; end
			default: mac_st = 1'b0;
		endcase
	end

	// the second product leaves the multiplier register in phase two
	assign sum = sub ? (SW'(first_q) - SW'(mul_q)) : (SW'(first_q) + SW'(mul_q));
	assign fin = mac_st && (ph_q == 2'd2);

	// radius band check
	assign rad_d    = SW'(unsigned'(sum));
	assign rad_diff = (rad_d >= SW'(ent.rsq)) ? (rad_d - SW'(ent.rsq)) : (SW'(ent.rsq) - rad_d);
	assign rad_bad  = rad_diff > SW'({tol_q, 16'b0});

	// segment: collinear within tolerance and inside the bounding box
	assign in_box = ((ent.sx < ent.ex) ? ent.sx : ent.ex) <= px &&
	                px <= ((ent.sx > ent.ex) ? ent.sx : ent.ex) &&
	                ((ent.sy < ent.ey) ? ent.sy : ent.ey) <= py &&
	                py <= ((ent.sy > ent.ey) ? ent.sy : ent.ey);
	assign seg_bad = ((c2_q << 32) > bm_p) || !in_box;

	// arc: sweep to the point no greater than sweep to the far end
	assign sweep_ok = (cls_v_q != cls_l_q) ? (cls_v_q < cls_l_q) :
	                  (cls_v_q[0] ? (sum >= 0) : 1'b1);

	assign cr_abs = cr_q[SW-1] ? SW'(-cr_q) : SW'(cr_q);

	// where to go once a point lies on the entry
	always_comb begin
		if (!pt_sel_q) begin
			ok_state = ent.arc ? ST_ARAD : ST_SEGX;
		end else if (dir_q != DIR_NONE) begin
			ok_state = ST_NEXT;
		end else if (!ent.arc && !q_arc_q) begin
			ok_state = ST_DIRS;
		end else if (ent.arc && q_arc_q) begin
			ok_state = ST_DIRA;
		end else begin
			ok_state = ST_NEXT;
		end
	end

	// multiplier and phase
	always_ff @(posedge clk) begin
		mul_q <= (ph_q == 2'd0) ? (x1 * y1) : (x2 * y2);
		if (ph_q == 2'd1) begin
			first_q <= mul_q;
		end
		t2_q <= tol_q * tol_q;
	end

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TW'(66);
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// query latch and kept partial results
	always_ff @(posedge clk) begin
		bm_start_q <= 1'b0;
		if (acc_in) begin
			q_arc_q <= in_ent.arc;
			q_ccw_q <= in_ent.ccw;
			qsx_q   <= in_ent.sx;
			qsy_q   <= in_ent.sy;
			qex_q   <= in_ent.ex;
			qey_q   <= in_ent.ey;
			qcx_q   <= in_ent.cx;
			qcy_q   <= in_ent.cy;
		end
		if (fin) begin
			unique case (state_q)
				ST_DEG:  ab2_q <= sum;
				ST_SEGX: cr_q  <= sum;
				ST_SEGA: begin
					ap2_q      <= sum;
					bm_start_q <= 1'b1;
					bm_a_q     <= BA'(cr_abs);
					bm_b_q     <= BB'(cr_abs);
				end
				ST_ARV:  xrv_q <= sum;
				ST_DRV:  cls_v_q <= sweep_cls(xrv_q, sum);
				ST_ARL:  xrl_q <= sum;
				ST_DRL:  cls_l_q <= sweep_cls(xrl_q, sum);
				default: ;
			endcase
		end
		if (bm_done) begin
			unique case (state_q)
				ST_BM1: begin
					c2_q       <= bm_p;
					bm_start_q <= 1'b1;
					bm_a_q     <= BA'(t2_q);
					bm_b_q     <= BB'(unsigned'(ab2_q));
				end
				ST_BM2: begin
					m2_q       <= bm_p[BA-1:0];
					bm_start_q <= 1'b1;
					bm_a_q     <= bm_p[BA-1:0];
					bm_b_q     <= BB'(unsigned'(ap2_q));
				end
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			k_q      <= '0;
			ph_q     <= '0;
			pt_sel_q <= 1'b0;
			on_q     <= 1'b0;
			dir_q    <= DIR_NONE;
			full_q   <= 1'b0;
			mvalid_q <= 1'b0;
			out_q    <= '0;
		end else begin
			if (mvalid_q && m_axis_tready) begin
				mvalid_q <= 1'b0;
			end
			if (mac_st) begin
				ph_q <= fin ? 2'd0 : ph_q + 2'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						on_q    <= 1'b0;
						dir_q   <= DIR_NONE;
						full_q  <= 1'b0;
						k_q     <= '0;
						state_q <= ST_DONE;
						case (in_req)
							REQ_CLEAR: count_q <= '0;
							REQ_APPEND: begin
								if (ram_we) count_q <= count_q + 1'b1;
								else full_q <= 1'b1;
							end
							REQ_TEST: begin
								if (count_q != '0) state_q <= ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_RD: begin
					pt_sel_q <= 1'b0;
					state_q  <= ST_DEG;
				end
				ST_DEG: begin
					// degenerate curves hold no point
					if (fin) begin
						if (unsigned'(sum) < SW'(t2_q)) state_q <= ST_NEXT;
						else state_q <= ent.arc ? ST_ARAD : ST_SEGX;
					end
				end
				ST_SEGX: if (fin) state_q <= ST_SEGA;
				ST_SEGA: if (fin) state_q <= ST_BM1;
				ST_BM1:  if (bm_done) state_q <= ST_BM2;
				ST_BM2:  if (bm_done) state_q <= ST_BM3;
				ST_BM3: begin
					if (bm_done) begin
						if (seg_bad) begin
							state_q <= ST_NEXT;
						end else begin
							state_q  <= ok_state;
							pt_sel_q <= 1'b1;
							if (pt_sel_q) on_q <= 1'b1;
						end
					end
				end
				ST_ARAD: begin
					if (fin) state_q <= rad_bad ? ST_NEXT : ST_ARV;
				end
				ST_ARV: if (fin) state_q <= ST_DRV;
				ST_DRV: if (fin) state_q <= ST_ARL;
				ST_ARL: if (fin) state_q <= ST_DRL;
				ST_DRL: if (fin) state_q <= ST_AVL;
				ST_AVL: begin
					if (fin) begin
						if (!sweep_ok) begin
							state_q <= ST_NEXT;
						end else begin
							state_q  <= ok_state;
							pt_sel_q <= 1'b1;
							if (pt_sel_q) on_q <= 1'b1;
						end
					end
				end
				ST_DIRS: begin
					if (fin) begin
						dir_q   <= (sum > 0) ? DIR_SAME : DIR_OPP;
						state_q <= ST_NEXT;
					end
				end
				ST_DIRA: begin
					// concentric arcs compare orientation, others let the scan go on
					if (fin) begin
						if (unsigned'(sum) < SW'(t2_q)) begin
							dir_q <= (ent.ccw == q_ccw_q) ? DIR_SAME : DIR_OPP;
						end
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					k_q     <= k_q + 1'b1;
					state_q <= ((k_q + 1'b1) == count_q) ? ST_DONE : ST_RD;
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (!mvalid_q || m_axis_tready) begin
						mvalid_q <= 1'b1;
						out_q    <= {full_q, dir_q, on_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = {{(OUT_W - 4){1'b0}}, out_q};

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// testbench of the boundary curve membership test: directed and random requests, scored in order
`default_nettype none
module tb;
	import bcmt_pkg::*;

	localparam req_t REQ_UNUSED = 2'd3;   // request code with no meaning; the block answers it with an empty result
	localparam int   TABLE_SIZE = 64;

	typedef logic signed [191:0] wide_t;

	// one request as the sender sees it
	typedef struct {
		req_t              req;
		logic              arc;
		logic              ccw;
		logic signed [31:0] sx, sy, ex, ey, cx, cy;
		logic [61:0]       rsq;
	} curve_req_t;

	// one result: on_boundary, direction, table_full
	typedef struct {
		logic       on;
		dir_t       dir;
		logic       full;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic [USER_W-1:0] s_axis_tuser = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [TW-1:0]     cfg_data = '0;

	boundary_curve_membership_test DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the curve table and the tolerance register
	logic [15:0] shadow_tol = 16'd66;
	int          shadow_count = 0;
	logic        tab_arc [TABLE_SIZE];
	logic        tab_ccw [TABLE_SIZE];
	longint      tab_sx [TABLE_SIZE], tab_sy [TABLE_SIZE];
	longint      tab_ex [TABLE_SIZE], tab_ey [TABLE_SIZE];
	longint      tab_cx [TABLE_SIZE], tab_cy [TABLE_SIZE];
	logic [61:0] tab_rsq [TABLE_SIZE];

	verdict_t pending_verdicts [$];
	int errors = 0;
	int n_sent = 0, n_checked = 0, n_hits = 0, n_full = 0;
	bit calm = 1'b0;           // set for stretches with no idling on either side
	int out_stall = 0;

	// ---------------------------------------------------------------- exact geometry
	function automatic wide_t mulw(longint a, longint b);
		wide_t x, y;
		x = a;
		y = b;
		return x * y;
	endfunction

	function automatic wide_t cross_w(longint ax, longint ay, longint bx, longint by);
		return mulw(ax, by) - mulw(ay, bx);
	endfunction

	function automatic wide_t dot_w(longint ax, longint ay, longint bx, longint by);
		return mulw(ax, bx) + mulw(ay, by);
	endfunction

	function automatic wide_t len_sq(longint dx, longint dy);
		return mulw(dx, dx) + mulw(dy, dy);
	endfunction

	// quadrant-like class of the ccw angle from r to v: 0 none, 1 up to half, 2 half, 3 beyond
	function automatic int angle_class(longint rx, longint ry, longint vx, longint vy);
		wide_t c;
		c = cross_w(rx, ry, vx, vy);
		if (c > 0) return 1;
		if (c < 0) return 3;
		if (dot_w(rx, ry, vx, vy) < 0) return 2;
		return 0;
	endfunction

	// ccw sweep from r to v no greater than from r to l
	function automatic bit sweep_ok(longint rx, longint ry, longint vx, longint vy,
			longint lx, longint ly);
		int a, b;
		a = angle_class(rx, ry, vx, vy);
		b = angle_class(rx, ry, lx, ly);
		if (a != b) return a < b;
		if (a == 1 || a == 3) return cross_w(vx, vy, lx, ly) >= 0;
		return 1'b1;
	endfunction

	function automatic bit holds_point(longint px, longint py, int k);
		wide_t t2, c, lhs, rhs, d, r, diff, tl;
		longint abx, aby, apx, apy, cx, cy;
		t2 = mulw(shadow_tol, shadow_tol);
		abx = tab_ex[k] - tab_sx[k];
		aby = tab_ey[k] - tab_sy[k];
		// degenerate curves hold nothing
		if (len_sq(abx, aby) < t2) return 1'b0;
		if (!tab_arc[k]) begin
			apx = px - tab_sx[k];
			apy = py - tab_sy[k];
			c = cross_w(abx, aby, apx, apy);
			lhs = (c * c) <<< 32;
			rhs = t2 * len_sq(abx, aby) * len_sq(apx, apy);
			if (lhs > rhs) return 1'b0;
			return ((tab_sx[k] < tab_ex[k] ? tab_sx[k] : tab_ex[k]) <= px) &&
				(px <= (tab_sx[k] > tab_ex[k] ? tab_sx[k] : tab_ex[k])) &&
				((tab_sy[k] < tab_ey[k] ? tab_sy[k] : tab_ey[k]) <= py) &&
				(py <= (tab_sy[k] > tab_ey[k] ? tab_sy[k] : tab_ey[k]));
		end
		cx = tab_cx[k];
		cy = tab_cy[k];
		d = len_sq(px - cx, py - cy);
		r = {130'b0, tab_rsq[k]};
		diff = (d >= r) ? d - r : r - d;
		tl = {160'b0, shadow_tol, 16'b0};
		if (diff > tl) return 1'b0;
		if (tab_ccw[k])
			return sweep_ok(tab_sx[k] - cx, tab_sy[k] - cy, px - cx, py - cy,
				tab_ex[k] - cx, tab_ey[k] - cy);
		return sweep_ok(tab_ex[k] - cx, tab_ey[k] - cy, px - cx, py - cy,
			tab_sx[k] - cx, tab_sy[k] - cy);
	endfunction

	// works out the result of one request and updates the shadow table
	function automatic verdict_t judge_request(curve_req_t it);
		verdict_t v;
		longint sx, sy, ex, ey, cx, cy;
		v.on = 1'b0;
		v.dir = DIR_NONE;
		v.full = 1'b0;
		sx = it.sx; sy = it.sy; ex = it.ex; ey = it.ey; cx = it.cx; cy = it.cy;
		case (it.req)
			REQ_CLEAR: begin
				shadow_count = 0;
			end
			REQ_APPEND: begin
				if (shadow_count < TABLE_SIZE) begin
					tab_arc[shadow_count] = it.arc;
					tab_ccw[shadow_count] = it.ccw;
					tab_sx[shadow_count] = sx; tab_sy[shadow_count] = sy;
					tab_ex[shadow_count] = ex; tab_ey[shadow_count] = ey;
					tab_cx[shadow_count] = cx; tab_cy[shadow_count] = cy;
					tab_rsq[shadow_count] = it.rsq;
					shadow_count++;
				end else begin
					v.full = 1'b1;
				end
			end
			REQ_TEST: begin
				for (int k = 0; k < shadow_count; k++) begin
					if (!(holds_point(sx, sy, k) && holds_point(ex, ey, k))) continue;
					v.on = 1'b1;
					if (v.dir != DIR_NONE) continue;
					if (!tab_arc[k] && !it.arc) begin
						v.dir = (dot_w(ex - sx, ey - sy, tab_ex[k] - tab_sx[k],
							tab_ey[k] - tab_sy[k]) > 0) ? DIR_SAME : DIR_OPP;
					end else if (tab_arc[k] && it.arc) begin
						if (len_sq(tab_cx[k] - cx, tab_cy[k] - cy) <
								mulw(shadow_tol, shadow_tol))
							v.dir = (tab_ccw[k] == it.ccw) ? DIR_SAME : DIR_OPP;
					end
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	// ---------------------------------------------------------------- request side
	task automatic send_request(input curve_req_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, it.rsq, it.cy, it.cx, it.ey, it.ex, it.sy, it.sx, it.ccw};
		s_axis_tuser <= {it.arc, it.req};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_verdicts.push_back(judge_request(it));
		n_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_tol = value;
	endtask

	function automatic curve_req_t blank_req(req_t req);
		curve_req_t it;
		it.req = req; it.arc = 1'b0; it.ccw = 1'b0;
		it.sx = 0; it.sy = 0; it.ex = 0; it.ey = 0; it.cx = 0; it.cy = 0; it.rsq = 0;
		return it;
	endfunction

	function automatic curve_req_t seg_req(req_t req, int sx, int sy, int ex, int ey);
		curve_req_t it;
		it = blank_req(req);
		it.sx = sx; it.sy = sy; it.ex = ex; it.ey = ey;
		return it;
	endfunction

	function automatic curve_req_t arc_req(req_t req, bit ccw, int sx, int sy, int ex, int ey,
			int cx, int cy, logic [61:0] rsq);
		curve_req_t it;
		it = seg_req(req, sx, sy, ex, ey);
		it.arc = 1'b1; it.ccw = ccw; it.cx = cx; it.cy = cy; it.rsq = rsq;
		return it;
	endfunction

	function automatic curve_req_t noise_req();
		curve_req_t it;
		it.req = req_t'($urandom_range(0, 3));
		it.arc = $urandom; it.ccw = $urandom;
		it.sx = $urandom; it.sy = $urandom; it.ex = $urandom; it.ey = $urandom;
		it.cx = $urandom; it.cy = $urandom;
		it.rsq = {$urandom, $urandom};
		return it;
	endfunction

	// ---------------------------------------------------------------- result side
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t unexpected result %h", $time, m_axis_tdata);
					errors++;
				end else begin
					verdict_t want;
					want = pending_verdicts.pop_front();
					n_checked++;
					if (m_axis_tdata[0] !== want.on) begin
						$display("%0t on_boundary expected %0d actual %0d", $time,
							want.on, m_axis_tdata[0]);
						errors++;
					end
					if (m_axis_tdata[2:1] !== want.dir) begin
						$display("%0t direction expected %0d actual %0d", $time,
							want.dir, m_axis_tdata[2:1]);
						errors++;
					end
					if (m_axis_tdata[3] !== want.full) begin
						$display("%0t table_full expected %0d actual %0d", $time,
							want.full, m_axis_tdata[3]);
						errors++;
					end
				end
				out_stall = calm ? 0 : $urandom_range(0, 12);
			end
			if (out_stall > 0) begin
				m_axis_tready <= 1'b0;
				out_stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- random geometry
	// lattice points of a circle of radius 5
	int lat_x [12] = '{5, 4, 3, 0, -3, -4, -5, -4, -3, 0, 3, 4};
	int lat_y [12] = '{0, 3, 4, 5, 4, 3, 0, -3, -4, -5, -4, -3};

	// how each stored curve was built, so queries can land on it
	bit g_arc [TABLE_SIZE];
	int g_ax [TABLE_SIZE], g_ay [TABLE_SIZE], g_dx [TABLE_SIZE], g_dy [TABLE_SIZE];
	int g_m [TABLE_SIZE], g_s [TABLE_SIZE];

	function automatic int jitter();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) - 3 : 0;
	endfunction

	task automatic add_random_curve(input int k);
		curve_req_t it;
		int i0, i1;
		g_arc[k] = $urandom_range(0, 1);
		g_ax[k] = $urandom_range(0, 1 << 22) - (1 << 21);
		g_ay[k] = $urandom_range(0, 1 << 22) - (1 << 21);
		if (!g_arc[k]) begin
			g_dx[k] = $urandom_range(0, 1 << 13) - (1 << 12);
			g_dy[k] = $urandom_range(0, 1 << 13) - (1 << 12);
			g_m[k] = $urandom_range(1, 8);
			it = seg_req(REQ_APPEND, g_ax[k], g_ay[k], g_ax[k] + g_m[k] * g_dx[k],
				g_ay[k] + g_m[k] * g_dy[k]);
		end else begin
			g_s[k] = $urandom_range(1, 1 << 10);
			i0 = $urandom_range(0, 11);
			i1 = $urandom_range(0, 11);
			it = arc_req(REQ_APPEND, $urandom, g_ax[k] + g_s[k] * lat_x[i0],
				g_ay[k] + g_s[k] * lat_y[i0], g_ax[k] + g_s[k] * lat_x[i1],
				g_ay[k] + g_s[k] * lat_y[i1], g_ax[k], g_ay[k],
				62'(25 * longint'(g_s[k]) * g_s[k]));
		end
		send_request(it);
	endtask

	task automatic query_near_curve(input int k);
		curve_req_t it;
		int i0, i1;
		if (!g_arc[k]) begin
			i0 = $urandom_range(0, g_m[k]);
			i1 = $urandom_range(0, g_m[k]);
			it = seg_req(REQ_TEST, g_ax[k] + i0 * g_dx[k] + jitter(),
				g_ay[k] + i0 * g_dy[k], g_ax[k] + i1 * g_dx[k],
				g_ay[k] + i1 * g_dy[k] + jitter());
			it.arc = ($urandom_range(0, 4) == 0);
			it.ccw = $urandom;
		end else begin
			i0 = $urandom_range(0, 11);
			i1 = $urandom_range(0, 11);
			it = arc_req(REQ_TEST, $urandom, g_ax[k] + g_s[k] * lat_x[i0] + jitter(),
				g_ay[k] + g_s[k] * lat_y[i0], g_ax[k] + g_s[k] * lat_x[i1],
				g_ay[k] + g_s[k] * lat_y[i1], g_ax[k] + 8 * jitter(), g_ay[k] + jitter(),
				{$urandom, $urandom});
			it.arc = ($urandom_range(0, 4) != 0);
		end
		send_request(it);
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_directed;
		// empty table after reset
		send_request(seg_req(REQ_TEST, 0, 0, 65536, 0));
		// degenerate segment is skipped, a real one below it is found
		send_request(seg_req(REQ_APPEND, 100, 100, 110, 100));
		send_request(seg_req(REQ_APPEND, 0, 0, 655360, 0));
		send_request(seg_req(REQ_TEST, 65536, 0, 131072, 0));
		send_request(seg_req(REQ_TEST, 131072, 0, 65536, 0));
		// zero-length query counts as opposite
		send_request(seg_req(REQ_TEST, 65536, 0, 65536, 0));
		// start point itself, off the box, just off the line but within tolerance
		send_request(seg_req(REQ_TEST, 0, 0, 655360, 0));
		send_request(seg_req(REQ_TEST, -1, 0, 655360, 0));
		send_request(seg_req(REQ_TEST, 65536, 40, 131072, 0));
		// arc query against a segment: held but no direction
		send_request(arc_req(REQ_TEST, 1'b1, 65536, 0, 131072, 0, 0, 0, 0));
		// half-circle arcs that wrap across angle zero
		send_request(arc_req(REQ_APPEND, 1'b1, 0, -327680, 0, 327680, 0, 0,
			62'(longint'(327680) * 327680)));
		send_request(arc_req(REQ_TEST, 1'b1, 196608, -262144, 262144, 196608, 0, 0, 0));
		send_request(arc_req(REQ_TEST, 1'b0, 262144, 196608, 196608, -262144, 0, 0, 0));
		send_request(arc_req(REQ_TEST, 1'b1, -327680, 0, 0, 327680, 0, 0, 0));
		send_request(arc_req(REQ_TEST, 1'b1, 196608, -262144, 262144, 196608, 70000, 0, 0));
		send_request(arc_req(REQ_APPEND, 1'b0, 0, 327680, 0, -327680, 0, 0,
			62'(longint'(327680) * 327680)));
		send_request(arc_req(REQ_TEST, 1'b1, -327680, 0, 0, 327680, 0, 0, 0));
		// extreme coordinates and radius
		send_request(seg_req(REQ_APPEND, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff));
		send_request(seg_req(REQ_TEST, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000));
		send_request(arc_req(REQ_APPEND, 1'b1, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, '1));
		send_request(arc_req(REQ_TEST, 1'b0, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1));
		// a random request, then an unused request code that leaves everything alone
		send_request(noise_req());
		begin
			curve_req_t odd;
			odd = noise_req();
			odd.req = REQ_UNUSED;
			send_request(odd);
		end
		send_request(blank_req(REQ_CLEAR));
		send_request(seg_req(REQ_TEST, 65536, 0, 131072, 0));
	endtask

	task automatic test_table_full;
		calm = 1'b1;
		send_request(blank_req(REQ_CLEAR));
		for (int k = 0; k < TABLE_SIZE; k++)
			add_random_curve(k);
		calm = 1'b0;
		repeat (3) begin
			send_request(seg_req(REQ_APPEND, 0, 0, 65536, 65536));
			n_full++;
		end
		repeat (4) query_near_curve($urandom_range(0, TABLE_SIZE - 1));
		send_request(blank_req(REQ_CLEAR));
	endtask

	task automatic test_random_phases;
		logic [15:0] tol_plan [8];
		int n_curves;
		tol_plan = '{16'd0, 16'hffff, 16'd66, 16'd1, 16'd4000, 16'd66, 16'd0, 16'hffff};
		for (int ph = 0; ph < 8; ph++) begin
			write_tolerance((ph == 5) ? 16'($urandom) : tol_plan[ph]);
			calm = (ph == 3);
			send_request(blank_req(REQ_CLEAR));
			n_curves = $urandom_range(1, 8);
			for (int k = 0; k < n_curves; k++)
				add_random_curve(k);
			repeat (50) begin
				if ($urandom_range(0, 6) == 0)
					send_request(noise_req());
				else
					query_near_curve($urandom_range(0, n_curves - 1));
			end
			// a noise append may have run past the geometry list; start over
			send_request(blank_req(REQ_CLEAR));
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_random_phases();
		drain();
		repeat (20) @(posedge clk);
		$display("sent %0d requests, checked %0d results, %0d over a full table",
			n_sent, n_checked, n_full);
		$display("covered clears, appends, queries on segments and arcs, eight tolerances");
		if (errors == 0 && pending_verdicts.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
